@@ src/nsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_pkg
// shared types, character codes and lookup functions of the nmea checker
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int MaxLineDefault = 512;
    localparam int LineLenWidth   = 10;

    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    localparam logic [39:0] ID_GPGGA = 40'h4750474741;
    localparam logic [39:0] ID_GPVTG = 40'h4750565447;
    localparam logic [39:0] ID_WIMDA = 40'h57494D4441;
    localparam logic [39:0] ID_WIMWV = 40'h57494D5756;
    localparam logic [39:0] ID_TIROT = 40'h5449524F54;
    localparam logic [39:0] ID_YXXDR = 40'h5958584452;

    typedef enum logic [2:0] {
        STATUS_OK,
        STATUS_NO_START,
        STATUS_NO_CHECKSUM,
        STATUS_MISMATCH,
        STATUS_TOO_LONG
    } status_t;

    typedef enum logic [2:0] {
        KIND_OTHER,
        KIND_GPGGA,
        KIND_GPVTG,
        KIND_WIMDA,
        KIND_WIMWV,
        KIND_TIROT,
        KIND_YXXDR
    } kind_t;

    // digits after the star
    typedef enum logic [1:0] {
        HEX_OPEN,
        HEX_ONE,
        HEX_DONE_VALUE,
        HEX_DONE_EMPTY
    } hex_state_t;

    typedef struct packed {
        status_t     status;
        kind_t       kind;
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
        logic [7:0]  field_count;
    } nsc_result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_of(input logic [7:0] b);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'h0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            d.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            d.value = 4'(b - 8'h37);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            d.value = 4'(b - 8'h57);
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    function automatic kind_t kind_of(input logic [39:0] id);
        kind_t k;
        case (id)
            ID_GPGGA: k = KIND_GPGGA;
            ID_GPVTG: k = KIND_GPVTG;
            ID_WIMDA: k = KIND_WIMDA;
            ID_WIMWV: k = KIND_WIMWV;
            ID_TIROT: k = KIND_TIROT;
            ID_YXXDR: k = KIND_YXXDR;
            default:  k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

@@ src/nsc_line_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_line_tracker
// per-line state: checksum, star snapshot, hex digits, identifier, commas
// and length; presents the line verdict from the current state
// ----------------------------------------------------------------------------
module nsc_line_tracker #(
    parameter int MAX_LINE = nsc_pkg::MaxLineDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output nsc_pkg::nsc_result_t result
);

    localparam logic [nsc_pkg::LineLenWidth-1:0] LINE_LIMIT =
        nsc_pkg::LineLenWidth'(MAX_LINE);
    localparam logic [nsc_pkg::LineLenWidth-1:0] LEN_MAX = '1;

    logic                              started_reg, started_next;
    logic [7:0]                        running_xor_reg, running_xor_next;
    logic [7:0]                        sum_at_star_reg, sum_at_star_next;
    logic                              star_seen_reg, star_seen_next;
    nsc_pkg::hex_state_t               hex_state_reg, hex_state_next;
    logic [7:0]                        hex_value_reg, hex_value_next;
    logic [39:0]                       id_chars_reg, id_chars_next;
    logic                              id_done_reg, id_done_next;
    logic [7:0]                        comma_count_reg, comma_count_next;
    logic [7:0]                        commas_at_star_reg, commas_at_star_next;
    logic [nsc_pkg::LineLenWidth-1:0]  line_length_reg, line_length_next;

    nsc_pkg::hex_digit_t digit;
    logic                have_digits;
    logic [8:0]          fields_sum;

    assign digit = nsc_pkg::hex_of(rx_byte);

    // next state
    always_comb
    begin
        started_next        = started_reg;
        running_xor_next    = running_xor_reg;
        sum_at_star_next    = sum_at_star_reg;
        star_seen_next      = star_seen_reg;
        hex_state_next      = hex_state_reg;
        hex_value_next      = hex_value_reg;
        id_chars_next       = id_chars_reg;
        id_done_next        = id_done_reg;
        comma_count_next    = comma_count_reg;
        commas_at_star_next = commas_at_star_reg;
        line_length_next    = line_length_reg;
        if (step)
        begin
            if (rx_byte == nsc_pkg::CHAR_NEWLINE)
            begin
                started_next        = 1'b0;
                running_xor_next    = '0;
                sum_at_star_next    = '0;
                star_seen_next      = 1'b0;
                hex_state_next      = nsc_pkg::HEX_OPEN;
                hex_value_next      = '0;
                id_chars_next       = '0;
                id_done_next        = 1'b0;
                comma_count_next    = '0;
                commas_at_star_next = '0;
                line_length_next    = '0;
            end
            else
            begin
                if (line_length_reg != LEN_MAX)
                begin
                    line_length_next = line_length_reg + 1'b1;
                end
                if (!started_reg)
                begin
                    if (rx_byte == nsc_pkg::CHAR_DOLLAR)
                    begin
                        started_next = 1'b1;
                    end
                end
                else
                begin
                    if (rx_byte == nsc_pkg::CHAR_STAR)
                    begin
                        sum_at_star_next    = running_xor_reg;
                        commas_at_star_next = comma_count_reg;
                        star_seen_next      = 1'b1;
                        hex_state_next      = nsc_pkg::HEX_OPEN;
                        hex_value_next      = '0;
                    end
                    else if (star_seen_reg && (hex_state_reg == nsc_pkg::HEX_OPEN ||
                                               hex_state_reg == nsc_pkg::HEX_ONE))
                    begin
                        if (!digit.valid)
                        begin
                            hex_state_next = (hex_state_reg == nsc_pkg::HEX_ONE) ?
                                nsc_pkg::HEX_DONE_VALUE : nsc_pkg::HEX_DONE_EMPTY;
                        end
                        else
                        begin
                            hex_value_next = {hex_value_reg[3:0], digit.value};
                            hex_state_next = (hex_state_reg == nsc_pkg::HEX_ONE) ?
                                nsc_pkg::HEX_DONE_VALUE : nsc_pkg::HEX_ONE;
                        end
                    end

                    if (!id_done_reg)
                    begin
                        if (rx_byte == nsc_pkg::CHAR_COMMA)
                        begin
                            id_done_next = 1'b1;
                        end
                        else if (rx_byte == nsc_pkg::CHAR_NUL || id_chars_reg[39:32] != 8'h00)
                        begin
                            id_done_next  = 1'b1;
                            id_chars_next = '0;
                        end
                        else
                        begin
                            id_chars_next = {id_chars_reg[31:0], rx_byte};
                        end
                    end

                    if (rx_byte == nsc_pkg::CHAR_COMMA && comma_count_reg != 8'hFF)
                    begin
                        comma_count_next = comma_count_reg + 8'd1;
                    end

                    running_xor_next = running_xor_reg ^ rx_byte;
                end
            end
        end
    end

    // verdict of the line so far
    always_comb
    begin
        have_digits = (hex_state_reg == nsc_pkg::HEX_ONE) ||
                      (hex_state_reg == nsc_pkg::HEX_DONE_VALUE);
        fields_sum  = {1'b0, (star_seen_reg ? commas_at_star_reg : comma_count_reg)} + 9'd1;

        result.kind         = nsc_pkg::KIND_OTHER;
        result.computed_sum = '0;
        result.received_sum = '0;
        result.field_count  = '0;
        if (started_reg)
        begin
            if (id_done_reg)
            begin
                result.kind = nsc_pkg::kind_of(id_chars_reg);
            end
            if (star_seen_reg)
            begin
                result.computed_sum = sum_at_star_reg;
            end
            if (star_seen_reg && have_digits)
            begin
                result.received_sum = hex_value_reg;
            end
            result.field_count = fields_sum[8] ? 8'hFF : fields_sum[7:0];
        end

        if (line_length_reg >= LINE_LIMIT)
        begin
            result.status = nsc_pkg::STATUS_TOO_LONG;
        end
        else if (!started_reg)
        begin
            result.status = nsc_pkg::STATUS_NO_START;
        end
        else if (!star_seen_reg || !have_digits)
        begin
            result.status = nsc_pkg::STATUS_NO_CHECKSUM;
        end
        else if (result.computed_sum != result.received_sum)
        begin
            result.status = nsc_pkg::STATUS_MISMATCH;
        end
        else
        begin
            result.status = nsc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg        <= 1'b0;
            running_xor_reg    <= '0;
            sum_at_star_reg    <= '0;
            star_seen_reg      <= 1'b0;
            hex_state_reg      <= nsc_pkg::HEX_OPEN;
            hex_value_reg      <= '0;
            id_chars_reg       <= '0;
            id_done_reg        <= 1'b0;
            comma_count_reg    <= '0;
            commas_at_star_reg <= '0;
            line_length_reg    <= '0;
        end
        else
        begin
            started_reg        <= started_next;
            running_xor_reg    <= running_xor_next;
            sum_at_star_reg    <= sum_at_star_next;
            star_seen_reg      <= star_seen_next;
            hex_state_reg      <= hex_state_next;
            hex_value_reg      <= hex_value_next;
            id_chars_reg       <= id_chars_next;
            id_done_reg        <= id_done_next;
            comma_count_reg    <= comma_count_next;
            commas_at_star_reg <= commas_at_star_next;
            line_length_reg    <= line_length_next;
        end
    end

endmodule

@@ src/nmea_sentence_checker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker_unit
// checks one nmea 0183 line per newline from a stream of received bytes
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_ready    rx_byte
//   out       output      out_valid / out_ready  status, sentence_kind,
//                                                computed_sum, received_sum,
//                                                field_count
//
// one byte per cycle unless the input is held: a byte is registered, then
// folded into the line state; a newline loads the verdict into the result register.
// out_valid rises when the registered newline is folded into the line state.
// rst_n clears the line state and both valid flags.
// only a newline waiting on a full, stalled result register holds the input.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_unit #(
    parameter int MAX_LINE = nsc_pkg::MaxLineDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [2:0] sentence_kind,
    output logic [7:0] computed_sum,
    output logic [7:0] received_sum,
    output logic [7:0] field_count
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg, out_valid_next;
    nsc_pkg::nsc_result_t result_reg;
    nsc_pkg::nsc_result_t line_result;
    logic                 is_newline;
    logic                 step;

    assign is_newline = (in_byte_reg == nsc_pkg::CHAR_NEWLINE);
    assign step       = in_valid_reg && (!is_newline || !out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || step;

    nsc_line_tracker #(
        .MAX_LINE (MAX_LINE)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .result  (line_result)
    );

    always_comb
    begin
        in_valid_next = in_ready ? in_valid : in_valid_reg;
        if (step && is_newline)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && is_newline)
        begin
            result_reg <= line_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign sentence_kind = result_reg.kind;
    assign computed_sum  = result_reg.computed_sum;
    assign received_sum  = result_reg.received_sum;
    assign field_count   = result_reg.field_count;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for nmea_sentence_checker_unit. nmea lines are fed one
// byte per transfer: a directed set of edge cases, then random sentences with
// noise, over phases of sender idling and receiver stalls. a line-state
// predictor builds the expected verdict on every newline. each verdict that
// leaves the block is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LINE_LIMIT  = nsc_pkg::MaxLineDefault;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_BYTES = 60;
    localparam int PHASE_LINES = 3;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        TAIL_GOOD,
        TAIL_LOWER,
        TAIL_BAD,
        TAIL_ONE_DIGIT,
        TAIL_BARE_STAR,
        TAIL_NO_STAR,
        TAIL_TWO_STARS,
        TAIL_TRAILING
    } tail_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] status;
    logic [2:0] sentence_kind;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [7:0] field_count;

    logic [7:0]           tx_bytes[$];
    nsc_pkg::nsc_result_t verdict_q[$];
    logic                 in_xfer        = 1'b0;
    int                   quiet_cycles   = 0;
    int                   fail_count     = 0;
    int                   pushed_bytes   = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;

    int send_pct_tab[4] = '{0, 58, 0, 27};
    int recv_pct_tab[4] = '{0, 0, 58, 27};

    string known_ids[6] = '{"GPGGA", "GPVTG", "WIMDA", "WIMWV", "TIROT", "YXXDR"};
    string field_chars  = "0123456789.-ABCDEFNSEW";

    // line state of the predictor
    logic                seen_dollar;
    logic [7:0]          xor_acc;
    logic [7:0]          xor_at_star;
    logic                seen_star;
    nsc_pkg::hex_state_t hex_st;
    logic [7:0]          hex_acc;
    logic [39:0]         id_acc;
    logic                id_closed;
    logic [7:0]          comma_acc;
    logic [7:0]          comma_at_star;
    logic [9:0]          line_len;

    nmea_sentence_checker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .sentence_kind (sentence_kind),
        .computed_sum  (computed_sum),
        .received_sum  (received_sum),
        .field_count   (field_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_line_state();
        seen_dollar   = 1'b0;
        xor_acc       = 8'h00;
        xor_at_star   = 8'h00;
        seen_star     = 1'b0;
        hex_st        = nsc_pkg::HEX_OPEN;
        hex_acc       = 8'h00;
        id_acc        = 40'h0;
        id_closed     = 1'b0;
        comma_acc     = 8'h00;
        comma_at_star = 8'h00;
        line_len      = 10'd0;
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            return {1'b1, b[3:0]};
        end
        if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
        begin
            return {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return 5'b0;
    endfunction

    function automatic nsc_pkg::nsc_result_t line_verdict();
        nsc_pkg::nsc_result_t r;
        logic                 have_digits;
        logic [8:0]           fields;
        r = '0;
        r.status = nsc_pkg::STATUS_OK;
        r.kind = nsc_pkg::KIND_OTHER;
        have_digits = (hex_st == nsc_pkg::HEX_ONE) || (hex_st == nsc_pkg::HEX_DONE_VALUE);
        if (seen_dollar)
        begin
            if (id_closed)
            begin
                case (id_acc)
                    nsc_pkg::ID_GPGGA: r.kind = nsc_pkg::KIND_GPGGA;
                    nsc_pkg::ID_GPVTG: r.kind = nsc_pkg::KIND_GPVTG;
                    nsc_pkg::ID_WIMDA: r.kind = nsc_pkg::KIND_WIMDA;
                    nsc_pkg::ID_WIMWV: r.kind = nsc_pkg::KIND_WIMWV;
                    nsc_pkg::ID_TIROT: r.kind = nsc_pkg::KIND_TIROT;
                    nsc_pkg::ID_YXXDR: r.kind = nsc_pkg::KIND_YXXDR;
                    default:           r.kind = nsc_pkg::KIND_OTHER;
                endcase
            end
            if (seen_star)
            begin
                r.computed_sum = xor_at_star;
            end
            if (seen_star && have_digits)
            begin
                r.received_sum = hex_acc;
            end
            fields = {1'b0, (seen_star ? comma_at_star : comma_acc)} + 9'd1;
            r.field_count = fields[8] ? 8'hFF : fields[7:0];
        end
        if (line_len >= 10'(LINE_LIMIT))
        begin
            r.status = nsc_pkg::STATUS_TOO_LONG;
        end
        else if (!seen_dollar)
        begin
            r.status = nsc_pkg::STATUS_NO_START;
        end
        else if (!seen_star || !have_digits)
        begin
            r.status = nsc_pkg::STATUS_NO_CHECKSUM;
        end
        else if (r.computed_sum != r.received_sum)
        begin
            r.status = nsc_pkg::STATUS_MISMATCH;
        end
        return r;
    endfunction

    function automatic void fold_byte(input logic [7:0] b);
        logic [4:0] nib;
        if (b == nsc_pkg::CHAR_NEWLINE)
        begin
            verdict_q.insert(verdict_q.size(), line_verdict());
            clear_line_state();
            return;
        end
        if (line_len != 10'h3FF)
        begin
            line_len = line_len + 10'd1;
        end
        if (!seen_dollar)
        begin
            if (b == nsc_pkg::CHAR_DOLLAR)
            begin
                seen_dollar = 1'b1;
            end
            return;
        end
        if (b == nsc_pkg::CHAR_STAR)
        begin
            xor_at_star   = xor_acc;
            comma_at_star = comma_acc;
            seen_star     = 1'b1;
            hex_st        = nsc_pkg::HEX_OPEN;
            hex_acc       = 8'h00;
        end
        else if (seen_star && (hex_st == nsc_pkg::HEX_OPEN || hex_st == nsc_pkg::HEX_ONE))
        begin
            nib = hex_nibble(b);
            if (nib[4])
            begin
                hex_acc = {hex_acc[3:0], nib[3:0]};
                hex_st  = (hex_st == nsc_pkg::HEX_OPEN) ?
                          nsc_pkg::HEX_ONE : nsc_pkg::HEX_DONE_VALUE;
            end
            else
            begin
                hex_st = (hex_st == nsc_pkg::HEX_ONE) ?
                         nsc_pkg::HEX_DONE_VALUE : nsc_pkg::HEX_DONE_EMPTY;
            end
        end
        if (!id_closed)
        begin
            if (b == nsc_pkg::CHAR_COMMA)
            begin
                id_closed = 1'b1;
            end
            else if (b == nsc_pkg::CHAR_NUL || id_acc[39:32] != 8'h00)
            begin
                id_closed = 1'b1;
                id_acc    = 40'h0;
            end
            else
            begin
                id_acc = {id_acc[31:0], b};
            end
        end
        if (b == nsc_pkg::CHAR_COMMA && comma_acc != 8'hFF)
        begin
            comma_acc = comma_acc + 8'd1;
        end
        xor_acc = xor_acc ^ b;
    endfunction

    task automatic note_fault(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endtask

    // driver: new byte or idle only after the previous transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_xfer)
            begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= tx_bytes[0];
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        nsc_pkg::nsc_result_t want;
        if (!rst_n)
        begin
            in_xfer      <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_xfer <= in_valid && in_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (in_valid && in_ready)
            begin
                fold_byte(rx_byte);
                void'(tx_bytes.pop_front());
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    note_fault($sformatf(
                        "unexpected verdict: status %0d kind %0d csum %02h rsum %02h fields %0d",
                        status, sentence_kind, computed_sum, received_sum, field_count));
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (status !== want.status || sentence_kind !== want.kind
                        || computed_sum !== want.computed_sum
                        || received_sum !== want.received_sum
                        || field_count !== want.field_count)
                    begin
                        note_fault($sformatf(
                            "verdict mismatch (status/kind/csum/rsum/fields): %s %0d/%0d/%02h/%02h/%0d %s %0d/%0d/%02h/%02h/%0d",
                            "expected", want.status, want.kind, want.computed_sum,
                            want.received_sum, want.field_count, "actual",
                            status, sentence_kind, computed_sum, received_sum, field_count));
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL nmea_sentence_checker_unit");
        $finish;
    end

    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
        pushed_bytes++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            queue_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10)
        begin
            return 8'h30 + 8'(v);
        end
        return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    task automatic push_sentence(input string body, input tail_t tail);
        logic [7:0] sum;
        logic [7:0] sent;
        logic [7:0] c_hi;
        logic [7:0] c_lo;
        logic [7:0] sum2;
        sum = 8'h00;
        for (int i = 0; i < body.len(); i++)
        begin
            sum = sum ^ body[i];
        end
        queue_byte(nsc_pkg::CHAR_DOLLAR);
        push_str(body);
        sent = (tail == TAIL_BAD) ? (sum ^ (8'h01 << $urandom_range(7))) : sum;
        c_hi = hex_char(sent[7:4], tail == TAIL_LOWER);
        c_lo = hex_char(sent[3:0], tail == TAIL_LOWER);
        if (tail != TAIL_NO_STAR)
        begin
            queue_byte(nsc_pkg::CHAR_STAR);
        end
        case (tail)
            TAIL_GOOD, TAIL_LOWER, TAIL_BAD, TAIL_TRAILING:
            begin
                queue_byte(c_hi);
                queue_byte(c_lo);
            end
            TAIL_ONE_DIGIT:
            begin
                queue_byte(c_lo);
            end
            TAIL_TWO_STARS:
            begin
                queue_byte(c_hi);
                queue_byte(c_lo);
                sum2 = sum ^ nsc_pkg::CHAR_STAR ^ c_hi ^ c_lo;
                queue_byte(nsc_pkg::CHAR_STAR);
                queue_byte(hex_char(sum2[7:4], 1'b0));
                queue_byte(hex_char(sum2[3:0], 1'b0));
            end
            default:
            begin
            end
        endcase
        if (tail == TAIL_TRAILING)
        begin
            queue_byte(hex_char(4'($urandom_range(15)), 1'b0));
            queue_byte(8'h0D);
        end
        queue_byte(nsc_pkg::CHAR_NEWLINE);
    endtask

    // whole line of n bytes before the newline
    task automatic push_padded(input int n);
        string body;
        body = "GPGGA,";
        while (body.len() < n - 4)
        begin
            body = {body, "1"};
        end
        push_sentence(body, TAIL_GOOD);
    endtask

    function automatic string random_body();
        string body;
        int    n;
        body = "";
        case ($urandom_range(9))
            0:
            begin
                n = $urandom_range(7, 3);
                repeat (n) body = {body, $sformatf("%c", 8'($urandom_range(90, 65)))};
            end
            1:
            begin
                repeat (5) body = {body, $sformatf("%c", 8'($urandom_range(90, 65)))};
            end
            default:
            begin
                body = known_ids[$urandom_range(5)];
            end
        endcase
        n = $urandom_range(8);
        repeat (n)
        begin
            body = {body, ","};
            repeat ($urandom_range(5))
            begin
                body = {body, $sformatf("%c", field_chars[$urandom_range(field_chars.len() - 1)])};
            end
        end
        return body;
    endfunction

    function automatic tail_t random_tail();
        if ($urandom_range(9) < 6)
        begin
            return TAIL_GOOD;
        end
        return tail_t'($urandom_range(int'(TAIL_TRAILING)));
    endfunction

    task automatic drain_all();
        while (tx_bytes.size() != 0 || in_valid || verdict_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        string body;
        int    ph;
        int    lines_in_phase;
        int    phase_start;
        int    pick;
        clear_line_state();
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed lines
        push_str("\n");
        push_str("GPGGA,1,2*00\n");
        foreach (known_ids[i])
        begin
            push_sentence({known_ids[i], ",1,2.5,N"}, TAIL_GOOD);
        end
        push_sentence("GPVTG,0.0,T", TAIL_LOWER);
        push_sentence("WIMDA,1", TAIL_BAD);
        push_sentence(",,", TAIL_ONE_DIGIT);
        push_sentence("WIMWV,1", TAIL_BARE_STAR);
        push_sentence("TIROT,1,2", TAIL_NO_STAR);
        push_sentence("YXXDR,1", TAIL_TWO_STARS);
        push_sentence("GPGGA,1", TAIL_TRAILING);
        push_sentence("GPGG,1", TAIL_GOOD);
        push_sentence("GPGGAX,1", TAIL_GOOD);
        push_sentence("GPGGA", TAIL_GOOD);
        // zero byte inside the identifier
        queue_byte(nsc_pkg::CHAR_DOLLAR);
        push_str("GP");
        queue_byte(nsc_pkg::CHAR_NUL);
        push_str("GA,1*00\n");
        push_sentence("$GPGGA,1", TAIL_GOOD);
        push_str("xy");
        queue_byte(8'hFF);
        push_sentence("GPVTG,2", TAIL_GOOD);
        push_str("$GPGGA,1* 1F\n");
        body = "GPGGA";
        repeat (260) body = {body, ","};
        push_sentence(body, TAIL_GOOD);
        push_padded(LINE_LIMIT - 1);
        push_padded(LINE_LIMIT);
        push_str("$\n");
        drain_all();

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pct_tab[ph];
            recv_stall_pct = recv_pct_tab[ph];
            phase_start    = pushed_bytes;
            lines_in_phase = 0;
            while (pushed_bytes - phase_start < PHASE_BYTES || lines_in_phase < PHASE_LINES)
            begin
                pick = $urandom_range(19);
                if (pick < 14)
                begin
                    push_sentence(random_body(), random_tail());
                end
                else if (pick < 16)
                begin
                    repeat ($urandom_range(5, 1)) queue_byte(8'($urandom_range(255)));
                    push_sentence(random_body(), random_tail());
                end
                else if (pick < 18)
                begin
                    repeat ($urandom_range(30, 1)) queue_byte(8'($urandom_range(255)));
                    queue_byte(nsc_pkg::CHAR_NEWLINE);
                end
                else
                begin
                    // sentence cut short by the newline
                    body = random_body();
                    queue_byte(nsc_pkg::CHAR_DOLLAR);
                    push_str(body.substr(0, $urandom_range(body.len() - 1)));
                    queue_byte(nsc_pkg::CHAR_NEWLINE);
                end
                lines_in_phase++;
            end
            drain_all();
        end

        repeat (12) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("PASS nmea_sentence_checker_unit");
        end
        else
        begin
            $display("FAIL nmea_sentence_checker_unit");
        end
        $finish;
    end

endmodule
